>>> hdl/lfps_pkg.sv
package lfps_pkg;

    localparam int unsigned POS_W      = 8;
    localparam int unsigned ERR_W      = 7;
    localparam int unsigned DERIV_W    = 8;
    localparam int unsigned INTEG_W    = 15;
    localparam int unsigned INTEG_EXT_W = INTEG_W + 2;
    localparam int unsigned GP_W       = 20;
    localparam int unsigned GI_W       = 17;
    localparam int unsigned GD_W       = 24;
    localparam int unsigned BASE_W     = 8;
    localparam int unsigned LIM_W      = 14;
    localparam int unsigned CORR_W     = 16;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned ACC_W      = 35;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned CORR_FULL_W = ACC_W - FRAC_W + 1;
    localparam int unsigned DUTY_SUM_W  = CORR_FULL_W + 1;

    localparam int unsigned DIV3_RECIP_W = 8;
    localparam int unsigned DIV3_SHIFT   = 9;
    localparam int unsigned DIV3_PROD_W  = POS_W + DIV3_RECIP_W;
    localparam logic [DIV3_RECIP_W-1:0] DIV3_RECIP = 8'd171;

    localparam logic signed [POS_W-1:0] LOST_CODE = 8'sd127;
    localparam logic [DUTY_W-1:0]       DUTY_MAX  = 8'd255;

    localparam logic [GP_W-1:0]   GAIN_PROP_RST   = 20'd163840;
    localparam logic [GI_W-1:0]   GAIN_INTEG_RST  = 17'd262;
    localparam logic [GD_W-1:0]   GAIN_DERIV_RST  = 24'd983040;
    localparam logic [BASE_W-1:0] BASE_SPEED_RST  = 8'd180;
    localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = 14'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP   = 3'd0,
        CFG_GAIN_INTEG  = 3'd1,
        CFG_GAIN_DERIV  = 3'd2,
        CFG_BASE_SPEED  = 3'd3,
        CFG_INTEG_LIMIT = 3'd4
    } t_cfg_idx;

    // signed divide by three, truncating toward zero, exact over the 8-bit range
    function automatic logic signed [ERR_W-1:0] div3(input logic signed [POS_W-1:0] v);
        logic [POS_W-1:0]       mag;
        logic [DIV3_PROD_W-1:0] prod;
        logic [ERR_W-1:0]       q;
        mag  = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
        prod = DIV3_PROD_W'(mag) * DIV3_PROD_W'(DIV3_RECIP);
        q    = prod[DIV3_SHIFT +: ERR_W];
        div3 = v[POS_W-1] ? ERR_W'(-q) : ERR_W'(q);
    endfunction

endpackage

>>> hdl/line_follow_pid_steering.sv
// Line-following PID steering for a differential drive.
//
// Input channel: i_valid / o_stall carry one signed line position per
// transaction; the code 127 marks a lost line. Output channel: o_valid /
// i_stall carry the left and right duties, the saturated correction and the
// line-lost flag, one result transaction per input transaction, in order.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// o_cfg_ready is always high and indexes beyond the register list are ignored.
//
// From input acceptance to o_valid a transaction passes the input register,
// state update (error, integral, derivative), three gain products, their sum,
// then magnitude shift, saturation and duty clamp into the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// the stage with the three multipliers bounds the clock.
//
// Reset clears the pipeline, the integral, derivative and error history, and
// loads the default gains, base speed and integral limit. While the receiver
// stalls, each stage still fills in behind a held result until the pipeline
// is full, then o_stall rises.
module line_follow_pid_steering (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [lfps_pkg::POS_W-1:0]       i_position,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic        [lfps_pkg::DUTY_W-1:0]      o_left_duty,
    output logic        [lfps_pkg::DUTY_W-1:0]      o_right_duty,
    output logic signed [lfps_pkg::CORR_W-1:0]      o_correction,
    output logic                                    o_line_lost,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic        [lfps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [lfps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic signed [lfps_pkg::CORR_FULL_W-1:0] CORR_MAX =
        lfps_pkg::CORR_FULL_W'((1 <<< (lfps_pkg::CORR_W - 1)) - 1);
    localparam logic signed [lfps_pkg::CORR_FULL_W-1:0] CORR_MIN =
        lfps_pkg::CORR_FULL_W'(-(1 <<< (lfps_pkg::CORR_W - 1)));

    logic [lfps_pkg::GP_W-1:0]   r_gain_prop;
    logic [lfps_pkg::GI_W-1:0]   r_gain_integ;
    logic [lfps_pkg::GD_W-1:0]   r_gain_deriv;
    logic [lfps_pkg::BASE_W-1:0] r_base_speed;
    logic [lfps_pkg::LIM_W-1:0]  r_integ_limit;

    logic signed [lfps_pkg::INTEG_W-1:0] r_integ, n_integ;
    logic signed [lfps_pkg::DERIV_W-1:0] r_deriv, n_deriv;
    logic signed [lfps_pkg::ERR_W-1:0]   r_hist [3];

    logic                                 r_v1, r_v2, r_v3, r_v4, r_vo;
    logic signed [lfps_pkg::POS_W-1:0]    r_pos1;
    logic                                 r_lost2, r_lost3, r_lost4;
    logic signed [lfps_pkg::ACC_W-1:0]    r_prod_p, r_prod_i, r_prod_d, r_acc;
    logic [lfps_pkg::DUTY_W-1:0]          r_left, r_right;
    logic signed [lfps_pkg::CORR_W-1:0]   r_corr;
    logic                                 r_lost_o;

    logic adv_o, adv4, adv3, adv2, adv1;

    logic                                      lost1;
    logic signed [lfps_pkg::ERR_W-1:0]         p_new;
    logic signed [lfps_pkg::INTEG_EXT_W-1:0]   integ_raw, lim_pos, lim_neg;

    logic signed [lfps_pkg::GP_W:0]            gp_s;
    logic signed [lfps_pkg::GI_W:0]            gi_s;
    logic signed [lfps_pkg::GD_W:0]            gd_s;

    logic                                      acc_neg;
    logic [lfps_pkg::ACC_W-1:0]                acc_mag;
    logic [lfps_pkg::CORR_FULL_W-2:0]          mag_sh;
    logic signed [lfps_pkg::CORR_FULL_W-1:0]   corr_full;
    logic signed [lfps_pkg::CORR_W-1:0]        corr_sat;
    logic signed [lfps_pkg::DUTY_SUM_W-1:0]    base_s, left_sum, right_sum;
    logic [lfps_pkg::DUTY_W-1:0]               left_clamp, right_clamp;

    // pipeline flow: each stage moves when the one after it is free or moving
    assign adv_o   = !r_vo || !i_stall;
    assign adv4    = !r_v4 || adv_o;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop   <= lfps_pkg::GAIN_PROP_RST;
            r_gain_integ  <= lfps_pkg::GAIN_INTEG_RST;
            r_gain_deriv  <= lfps_pkg::GAIN_DERIV_RST;
            r_base_speed  <= lfps_pkg::BASE_SPEED_RST;
            r_integ_limit <= lfps_pkg::INTEG_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (lfps_pkg::t_cfg_idx'(i_cfg_index))
                lfps_pkg::CFG_GAIN_PROP:   r_gain_prop   <= i_cfg_data[lfps_pkg::GP_W-1:0];
                lfps_pkg::CFG_GAIN_INTEG:  r_gain_integ  <= i_cfg_data[lfps_pkg::GI_W-1:0];
                lfps_pkg::CFG_GAIN_DERIV:  r_gain_deriv  <= i_cfg_data[lfps_pkg::GD_W-1:0];
                lfps_pkg::CFG_BASE_SPEED:  r_base_speed  <= i_cfg_data[lfps_pkg::BASE_W-1:0];
                lfps_pkg::CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[lfps_pkg::LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // error, integral and derivative update
    always_comb begin
        lost1     = (r_pos1 == lfps_pkg::LOST_CODE);
        p_new     = lfps_pkg::div3(r_pos1);
        integ_raw = lfps_pkg::INTEG_EXT_W'(r_integ) + lfps_pkg::INTEG_EXT_W'(p_new);
        lim_pos   = signed'(lfps_pkg::INTEG_EXT_W'(r_integ_limit));
        lim_neg   = -lim_pos;
        if (lost1) begin
            n_integ = r_integ;
            n_deriv = r_deriv;
        end else begin
            if (integ_raw > lim_pos) begin
                n_integ = lfps_pkg::INTEG_W'(lim_pos);
            end else if (integ_raw < lim_neg) begin
                n_integ = lfps_pkg::INTEG_W'(lim_neg);
            end else begin
                n_integ = lfps_pkg::INTEG_W'(integ_raw);
            end
            n_deriv = lfps_pkg::DERIV_W'(p_new) - lfps_pkg::DERIV_W'(r_hist[2]);
        end
    end

    // gains as non-negative signed operands
    assign gp_s = signed'({1'b0, r_gain_prop});
    assign gi_s = signed'({1'b0, r_gain_integ});
    assign gd_s = signed'({1'b0, r_gain_deriv});

    // truncate toward zero, saturate, clamp duties
    always_comb begin
        acc_neg   = r_acc[lfps_pkg::ACC_W-1];
        acc_mag   = acc_neg ? lfps_pkg::ACC_W'(-r_acc) : lfps_pkg::ACC_W'(r_acc);
        mag_sh    = acc_mag[lfps_pkg::ACC_W-1:lfps_pkg::FRAC_W];
        corr_full = acc_neg ? -signed'({1'b0, mag_sh}) : signed'({1'b0, mag_sh});
        if (corr_full > CORR_MAX) begin
            corr_sat = lfps_pkg::CORR_W'(CORR_MAX);
        end else if (corr_full < CORR_MIN) begin
            corr_sat = lfps_pkg::CORR_W'(CORR_MIN);
        end else begin
            corr_sat = lfps_pkg::CORR_W'(corr_full);
        end
        base_s    = signed'(lfps_pkg::DUTY_SUM_W'(r_base_speed));
        left_sum  = base_s + lfps_pkg::DUTY_SUM_W'(corr_full);
        right_sum = base_s - lfps_pkg::DUTY_SUM_W'(corr_full);
        if (left_sum < 0) begin
            left_clamp = '0;
        end else if (left_sum > signed'(lfps_pkg::DUTY_SUM_W'(lfps_pkg::DUTY_MAX))) begin
            left_clamp = lfps_pkg::DUTY_MAX;
        end else begin
            left_clamp = left_sum[lfps_pkg::DUTY_W-1:0];
        end
        if (right_sum < 0) begin
            right_clamp = '0;
        end else if (right_sum > signed'(lfps_pkg::DUTY_SUM_W'(lfps_pkg::DUTY_MAX))) begin
            right_clamp = lfps_pkg::DUTY_MAX;
        end else begin
            right_clamp = right_sum[lfps_pkg::DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_vo      <= 1'b0;
            r_integ   <= '0;
            r_deriv   <= '0;
            r_hist[0] <= '0;
            r_hist[1] <= '0;
            r_hist[2] <= '0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
                if (r_v1) begin
                    r_integ <= n_integ;
                    r_deriv <= n_deriv;
                    if (!lost1) begin
                        r_hist[2] <= r_hist[1];
                        r_hist[1] <= r_hist[0];
                        r_hist[0] <= p_new;
                    end
                end
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
            if (adv_o) begin
                r_vo <= r_v4;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_pos1 <= i_position;
        end
        if (adv2 && r_v1) begin
            r_lost2 <= lost1;
        end
        if (adv3 && r_v2) begin
            r_lost3  <= r_lost2;
            r_prod_p <= lfps_pkg::ACC_W'(gp_s) * lfps_pkg::ACC_W'(r_hist[0]);
            r_prod_i <= lfps_pkg::ACC_W'(gi_s) * lfps_pkg::ACC_W'(r_integ);
            r_prod_d <= lfps_pkg::ACC_W'(gd_s) * lfps_pkg::ACC_W'(r_deriv);
        end
        if (adv4 && r_v3) begin
            r_lost4 <= r_lost3;
            r_acc   <= r_prod_p + r_prod_i + r_prod_d;
        end
        if (adv_o && r_v4) begin
            r_lost_o <= r_lost4;
            r_corr   <= corr_sat;
            r_left   <= left_clamp;
            r_right  <= right_clamp;
        end
    end

    assign o_valid      = r_vo;
    assign o_left_duty  = r_left;
    assign o_right_duty = r_right;
    assign o_correction = r_corr;
    assign o_line_lost  = r_lost_o;

endmodule

>>> sim/line_follow_pid_steering_test.sv
module line_follow_pid_steering_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PHASES      = 6;
    localparam int     PHASE_ITEMS = 272;
    localparam int     DRAIN_SLACK = 12;
    localparam int     CYCLE_LIMIT = 300000;
    localparam longint CORR_MAX    = 32767;
    localparam longint CORR_MIN    = -32768;

    localparam logic [lfps_pkg::CFG_DATA_W-1:0] GP_HIGH   = 24'd589824;
    localparam logic [lfps_pkg::CFG_DATA_W-1:0] GI_HIGH   = 24'd65536;
    localparam logic [lfps_pkg::CFG_DATA_W-1:0] GD_HIGH   = 24'd13107200;
    localparam logic [lfps_pkg::CFG_DATA_W-1:0] BASE_HIGH = 24'd255;
    localparam logic [lfps_pkg::CFG_DATA_W-1:0] LIM_HIGH  = 24'd16383;

    typedef struct {
        logic        [lfps_pkg::DUTY_W-1:0] left_duty;
        logic        [lfps_pkg::DUTY_W-1:0] right_duty;
        logic signed [lfps_pkg::CORR_W-1:0] correction;
        logic                               line_lost;
    } t_steer_out;

    class t_duty_ledger;
        logic [lfps_pkg::GP_W-1:0]   gain_prop;
        logic [lfps_pkg::GI_W-1:0]   gain_integ;
        logic [lfps_pkg::GD_W-1:0]   gain_deriv;
        logic [lfps_pkg::BASE_W-1:0] base_speed;
        logic [lfps_pkg::LIM_W-1:0]  integ_limit;
        int                          integ_sum;
        int                          deriv_term;
        int                          err_hist[3];
        t_steer_out                  pending_duties[$];
        int                          mismatches;

        function new();
            gain_prop   = lfps_pkg::GAIN_PROP_RST;
            gain_integ  = lfps_pkg::GAIN_INTEG_RST;
            gain_deriv  = lfps_pkg::GAIN_DERIV_RST;
            base_speed  = lfps_pkg::BASE_SPEED_RST;
            integ_limit = lfps_pkg::INTEG_LIMIT_RST;
            integ_sum   = 0;
            deriv_term  = 0;
            err_hist    = '{0, 0, 0};
            mismatches  = 0;
        endfunction

        function void set_reg(logic [lfps_pkg::CFG_IDX_W-1:0] idx,
                              logic [lfps_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lfps_pkg::CFG_GAIN_PROP:   gain_prop   = data[lfps_pkg::GP_W-1:0];
                lfps_pkg::CFG_GAIN_INTEG:  gain_integ  = data[lfps_pkg::GI_W-1:0];
                lfps_pkg::CFG_GAIN_DERIV:  gain_deriv  = data[lfps_pkg::GD_W-1:0];
                lfps_pkg::CFG_BASE_SPEED:  base_speed  = data[lfps_pkg::BASE_W-1:0];
                lfps_pkg::CFG_INTEG_LIMIT: integ_limit = data[lfps_pkg::LIM_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [lfps_pkg::DUTY_W-1:0] clamp_duty(longint v);
            if (v < 0) return '0;
            if (v > longint'(lfps_pkg::DUTY_MAX)) return lfps_pkg::DUTY_MAX;
            return lfps_pkg::DUTY_W'(v);
        endfunction

        function void take_position(logic signed [lfps_pkg::POS_W-1:0] pos);
            t_steer_out r;
            int         err;
            int         lim;
            longint     acc;
            longint     corr;
            longint     sat;
            lim = int'(integ_limit);
            r.line_lost = (pos == lfps_pkg::LOST_CODE);
            if (r.line_lost) begin
                err = err_hist[0];
            end else begin
                err = int'(pos) / 3;
                deriv_term = err - err_hist[2];
                integ_sum += err;
                if (integ_sum > lim) integ_sum = lim;
                else if (integ_sum < -lim) integ_sum = -lim;
                err_hist[2] = err_hist[1];
                err_hist[1] = err_hist[0];
                err_hist[0] = err;
            end
            acc = longint'(gain_prop) * err + longint'(gain_integ) * integ_sum
                + longint'(gain_deriv) * deriv_term;
            corr = (acc < 0) ? -((-acc) >>> lfps_pkg::FRAC_W) : (acc >>> lfps_pkg::FRAC_W);
            sat = corr;
            if (sat > CORR_MAX) sat = CORR_MAX;
            else if (sat < CORR_MIN) sat = CORR_MIN;
            r.correction = lfps_pkg::CORR_W'(sat);
            r.left_duty  = clamp_duty(longint'(base_speed) + corr);
            r.right_duty = clamp_duty(longint'(base_speed) - corr);
            pending_duties.push_back(r);
        endfunction

        function void check_duty(t_steer_out got);
            t_steer_out want;
            if (pending_duties.size() == 0) begin
                $display("%0t: result with none expected: left %0d right %0d corr %0d lost %0b",
                         $time, got.left_duty, got.right_duty, got.correction, got.line_lost);
                mismatches++;
                return;
            end
            want = pending_duties.pop_front();
            if (got.left_duty !== want.left_duty) begin
                $display("%0t: left_duty expected %0d actual %0d",
                         $time, want.left_duty, got.left_duty);
                mismatches++;
            end
            if (got.right_duty !== want.right_duty) begin
                $display("%0t: right_duty expected %0d actual %0d",
                         $time, want.right_duty, got.right_duty);
                mismatches++;
            end
            if (got.correction !== want.correction) begin
                $display("%0t: correction expected %0d actual %0d",
                         $time, want.correction, got.correction);
                mismatches++;
            end
            if (got.line_lost !== want.line_lost) begin
                $display("%0t: line_lost expected %0b actual %0b",
                         $time, want.line_lost, got.line_lost);
                mismatches++;
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic signed [lfps_pkg::POS_W-1:0]  i_position;
    logic                               o_valid;
    logic                               i_stall;
    logic [lfps_pkg::DUTY_W-1:0]        o_left_duty;
    logic [lfps_pkg::DUTY_W-1:0]        o_right_duty;
    logic signed [lfps_pkg::CORR_W-1:0] o_correction;
    logic                               o_line_lost;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [lfps_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [lfps_pkg::CFG_DATA_W-1:0]    i_cfg_data;

    t_duty_ledger ledger;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           positions_sent = 0;
    int           lost_sent      = 0;
    int           reg_writes     = 0;
    int           cycles         = 0;

    line_follow_pid_steering dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_left_duty  (o_left_duty),
        .o_right_duty (o_right_duty),
        .o_correction (o_correction),
        .o_line_lost  (o_line_lost),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_steer_out got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.left_duty  = o_left_duty;
            got.right_duty = o_right_duty;
            got.correction = o_correction;
            got.line_lost  = o_line_lost;
            ledger.check_duty(got);
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_position(input logic signed [lfps_pkg::POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_position <= pos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ledger.take_position(pos);
        positions_sent++;
        if (pos == lfps_pkg::LOST_CODE) lost_sent++;
    endtask

    task automatic write_reg(input logic [lfps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfps_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ledger.set_reg(idx, data);
        reg_writes++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (ledger.pending_duties.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    function automatic logic [lfps_pkg::CFG_DATA_W-1:0] pick_value(lfps_pkg::t_cfg_idx idx,
                                                                  int k);
        logic [lfps_pkg::CFG_DATA_W-1:0] high;
        case (idx)
            lfps_pkg::CFG_GAIN_PROP:   high = GP_HIGH;
            lfps_pkg::CFG_GAIN_INTEG:  high = GI_HIGH;
            lfps_pkg::CFG_GAIN_DERIV:  high = GD_HIGH;
            lfps_pkg::CFG_BASE_SPEED:  high = BASE_HIGH;
            default:                   high = LIM_HIGH;
        endcase
        if (k == 0) return high;
        if (k == 1) return '0;
        case ($urandom_range(3))
            0:       return '0;
            1:       return high;
            2:       return lfps_pkg::CFG_DATA_W'($urandom_range(high));
            default: return lfps_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic program_setting(input int k);
        for (int r = lfps_pkg::CFG_GAIN_PROP; r <= lfps_pkg::CFG_INTEG_LIMIT; r++)
            write_reg(lfps_pkg::CFG_IDX_W'(r), pick_value(lfps_pkg::t_cfg_idx'(r), k));
        write_reg(lfps_pkg::CFG_IDX_W'($urandom_range(lfps_pkg::CFG_INTEG_LIMIT + 1,
                                                      (1 << lfps_pkg::CFG_IDX_W) - 1)),
                  lfps_pkg::CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [lfps_pkg::POS_W-1:0] pick_position(
        logic signed [lfps_pkg::POS_W-1:0] prev);
        int roll;
        int w;
        roll = $urandom_range(99);
        if (roll < 12) return lfps_pkg::LOST_CODE;
        if (roll < 55) begin
            w = int'(prev) + int'($urandom_range(16)) - 8;
            if (w > int'(lfps_pkg::LOST_CODE) - 1) w = int'(lfps_pkg::LOST_CODE) - 1;
            if (w < -(1 << (lfps_pkg::POS_W - 1))) w = -(1 << (lfps_pkg::POS_W - 1));
            return lfps_pkg::POS_W'(w);
        end
        return lfps_pkg::POS_W'($urandom_range(255));
    endfunction

    task automatic run_phase(input int k, input int items);
        logic signed [lfps_pkg::POS_W-1:0] pos;
        int                                sent;
        bit                                paused;
        pos    = '0;
        sent   = 0;
        paused = 1'b0;
        wait_drained();
        program_setting(k);
        while (sent < items) begin
            if (!paused && sent >= items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(39) == 0) begin
                repeat ($urandom_range(2, 6)) begin
                    send_position(lfps_pkg::LOST_CODE);
                    sent++;
                end
            end else begin
                pos = pick_position(pos);
                send_position(pos);
                sent++;
            end
        end
    endtask

    initial begin
        logic signed [lfps_pkg::POS_W-1:0] opening[$];
        opening = '{lfps_pkg::LOST_CODE, 8'sd0, 8'sd1, 8'sd2, 8'sd3, -8'sd1, -8'sd2, -8'sd3,
                    -8'sd128, 8'sd126, lfps_pkg::LOST_CODE, lfps_pkg::LOST_CODE, -8'sd127,
                    8'sd125, 8'sd64, -8'sd64, 8'sd0};
        ledger = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_position  <= '0;
        i_stall     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[n]) send_position(opening[n]);

        wait_drained();
        write_reg(lfps_pkg::CFG_GAIN_INTEG, GI_HIGH);
        write_reg(lfps_pkg::CFG_INTEG_LIMIT, 24'd50);
        i_cfg_valid <= 1'b0;
        repeat (4) send_position(-8'sd128);
        wait_drained();
        write_reg(lfps_pkg::CFG_INTEG_LIMIT, 24'd10);
        i_cfg_valid <= 1'b0;
        send_position(lfps_pkg::LOST_CODE);
        send_position(-8'sd3);

        for (int k = 0; k < PHASES; k++) begin
            case (k / 2)
                0: begin
                    send_idle_pct  = 31;
                    recv_stall_pct = 83;
                end
                1: begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 31;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            run_phase(k, PHASE_ITEMS);
        end
        wait_drained();

        $display("run covered %0d line positions (%0d lost-line) and %0d register writes",
                 positions_sent, lost_sent, reg_writes);
        $display("over %0d gain settings, with mixed source gaps and sink back-pressure",
                 PHASES + 3);
        if (ledger.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/lfps_pkg.sv
hdl/line_follow_pid_steering.sv
sim/line_follow_pid_steering_test.sv
